/* rtl/hsc_pkg.sv */
`default_nettype none
package hsc_pkg;

    // block geometry
    localparam int DATA_BYTES = 4;
    localparam int WORD_BITS  = 40;
    localparam int DATA_BITS  = 8 * DATA_BYTES;

    // number of power-of-two positions passed while placing the data bits
    function automatic int calc_check_count(input int d);
        int placed;
        int pos;
        int p;
        placed = 0;
        pos    = 0;
        p      = 0;
        while (placed < d) begin
            pos++;
            if ((pos & (pos - 1)) == 0) p++;
            else placed++;
        end
        return p;
    endfunction

    localparam int CHECK_BITS = calc_check_count(DATA_BITS);
    localparam int CODE_BITS  = DATA_BITS + CHECK_BITS;
    localparam int FRAME_BITS = 8 * ((CHECK_BITS + DATA_BITS + 8) / 8);
    localparam int SYN_W      = $clog2(CODE_BITS + 1);
    localparam int WIDE_BITS  = (FRAME_BITS > WORD_BITS) ? FRAME_BITS : WORD_BITS;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [FRAME_BITS-1:0] t_frame;
    typedef logic [DATA_BITS-1:0]  t_data;
    typedef logic [WIDE_BITS-1:0]  t_wide;
    typedef logic [SYN_W-1:0]      t_syn;
    typedef logic [1:0]            t_status;

    // status codes
    localparam t_status STATUS_CLEAN         = 2'd0;
    localparam t_status STATUS_CORRECTED     = 2'd1;
    localparam t_status STATUS_UNCORRECTABLE = 2'd2;

    // codec modes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // codeword position (from 1) that carries data bit i
    function automatic int data_pos(input int i);
        int pos;
        int di;
        int found;
        pos   = 0;
        di    = -1;
        found = 0;
        while (di < i) begin
            pos++;
            if ((pos & (pos - 1)) != 0) di++;
        end
        found = pos;
        return found;
    endfunction

    // frame bits covered by syndrome bit k
    function automatic t_frame syn_mask(input int k);
        t_frame m;
        m = '0;
        for (int pos = 1; pos <= CODE_BITS; pos++) begin
            if (((pos >> k) & 1) != 0) m[pos-1] = 1'b1;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* rtl/hamming_secded_codec_top.sv */
// an input transfer is held in the input register, then its result in the result register that drives the output
// throughput: one item per cycle, sustained while the result side keeps taking transfers
// the codec is one pass of xor trees between the two registers
// reset (synchronous, active low) empties both stages and sets the mode to encode
// configuration writes are always taken
`default_nettype none
module hamming_secded_codec_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic             i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire hsc_pkg::t_word   i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output hsc_pkg::t_word        o_out_word,
    output hsc_pkg::t_status      o_status
);
    import hsc_pkg::*;

    logic    r_mode;
    logic    r_in_valid;
    t_word   r_in_word;
    logic    r_out_valid;
    t_word   r_out_word;
    t_status r_status;
    logic    n_in_valid;
    logic    n_out_valid;
    logic    advance;
    t_word   res_word;
    t_status res_status;

    // flow control
    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign n_in_valid  = o_in_ready ? i_in_valid : r_in_valid;
    assign n_out_valid = advance ? r_in_valid : r_out_valid;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCODE;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    hsc_codec u_codec (
        .i_mode   (r_mode),
        .i_word   (r_in_word),
        .o_word   (res_word),
        .o_status (res_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_word <= res_word;
            r_status   <= res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_status    = r_status;

endmodule
`default_nettype wire

/* rtl/hsc_codec.sv */
`default_nettype none
module hsc_codec (
    input  wire logic             i_mode,
    input  wire hsc_pkg::t_word   i_word,
    output hsc_pkg::t_word        o_word,
    output hsc_pkg::t_status      o_status
);
    import hsc_pkg::*;

    t_data   enc_data;
    t_frame  enc_data_cw;
    t_frame  enc_cw;
    t_frame  dec_frame;
    t_frame  dec_fixed;
    t_data   dec_data;
    t_syn    syn;
    logic    overall;
    logic    flip;
    t_status dec_status;

    // data block and frame views of the input word
    assign enc_data  = DATA_BITS'(t_wide'(i_word));
    assign dec_frame = FRAME_BITS'(t_wide'(i_word));

    // place data bits at the non power-of-two positions
    always_comb begin
        enc_data_cw = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            enc_data_cw[data_pos(i)-1] = enc_data[i];
        end
    end

    // check bits, then overall parity in the top frame bit
    always_comb begin
        enc_cw = enc_data_cw;
        for (int k = 0; k < CHECK_BITS; k++) begin
            enc_cw[(1 << k) - 1] = ^(enc_data_cw & syn_mask(k));
        end
        enc_cw[FRAME_BITS-1] = ^enc_cw;
    end

    // syndrome and overall check of the received frame
    for (genvar k = 0; k < SYN_W; k++) begin : g_syn
        assign syn[k] = ^(dec_frame & syn_mask(k));
    end
    assign overall = ^dec_frame;

    // classify the frame
    always_comb begin
        flip       = 1'b0;
        dec_status = STATUS_CLEAN;
        if (syn == '0) begin
            if (overall) dec_status = STATUS_CORRECTED;
        end else if (!overall) begin
            dec_status = STATUS_UNCORRECTABLE;
        end else if (syn <= SYN_W'(CODE_BITS)) begin
            flip       = 1'b1;
            dec_status = STATUS_CORRECTED;
        end else begin
            dec_status = STATUS_UNCORRECTABLE;
        end
    end

    // single bit repair and data extraction
    assign dec_fixed = flip ? (dec_frame ^ (t_frame'(1) << (syn - t_syn'(1)))) : dec_frame;

    always_comb begin
        dec_data = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            dec_data[i] = dec_fixed[data_pos(i)-1];
        end
    end

    // result select
    always_comb begin
        if (i_mode == MODE_DECODE) begin
            o_word   = WORD_BITS'(t_wide'(dec_data));
            o_status = dec_status;
        end else begin
            o_word   = WORD_BITS'(t_wide'(enc_cw));
            o_status = STATUS_CLEAN;
        end
    end

endmodule
`default_nettype wire
